// ===== src/tpl_pkg.sv =====
// Shared types and constants for the triangle point locator.
// No dependencies.
package tpl_pkg;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam int CfgWidth = 7;
  localparam int IndexWidth = 6;

endpackage

// ===== src/tpl_front.sv =====
// Front end: accepts items and queues them for the scan engine.
// Depends on tpl_pkg.
module tpl_front import tpl_pkg::*; #(
  parameter int ItemWidth = 8,
  parameter int Depth     = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ItemWidth-1:0] in_item_i,
  output logic                 q_valid_o,
  input  logic                 q_pop_i,
  output logic [ItemWidth-1:0] q_item_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [ItemWidth-1:0] mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0]   cnt_q;
  logic push, pop;

  assign in_stall_o = (cnt_q == (PtrW+1)'(Depth));
  assign push = in_valid_i && !in_stall_o;
  assign q_valid_o = (cnt_q != '0);
  assign pop = q_pop_i && q_valid_o;
  assign q_item_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= (wptr_q == PtrW'(Depth-1)) ? '0 : wptr_q + 1'b1;
      if (pop)  rptr_q <= (rptr_q == PtrW'(Depth-1)) ? '0 : rptr_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

// ===== src/tpl_back.sv =====
// Back end: triangle table memory and the shared containment tester.
// Depends on tpl_pkg.
module tpl_back import tpl_pkg::*; #(
  parameter int MaxTriangles = 64,
  parameter int CoordBits    = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [CfgWidth-1:0]    count_i,
  input  logic                   q_valid_i,
  output logic                   q_pop_o,
  input  logic                   cmd_i,
  input  logic [IndexWidth-1:0]  slot_i,
  input  logic [6*CoordBits-1:0] tri_i,
  input  logic [2*CoordBits-1:0] point_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   found_o,
  output logic [IndexWidth-1:0]  index_o
);

  localparam int AddrW = (MaxTriangles > 1) ? $clog2(MaxTriangles) : 1;
  localparam int CntW  = $clog2(MaxTriangles + 1);
  localparam int DW    = CoordBits + 1;
  localparam int PW    = 2 * DW + 2;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_MUL  = 5'b00100,
    S_TEST = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [6*CoordBits-1:0] mem_q [MaxTriangles];
  logic [6*CoordBits-1:0] rd_q;
  logic [CntW-1:0] idx_q, n_q;
  logic signed [CoordBits-1:0] px_q, pz_q;
  logic signed [PW-1:0] m_q [6];
  logic hit_q;
  logic [IndexWidth-1:0] hit_idx_q;
  logic found_q;
  logic [IndexWidth-1:0] res_q;
  logic out_valid_q;

  logic signed [CoordBits-1:0] ax, az, bx, bz, cx, cz;
  logic signed [DW-1:0] e0, e1, e2, e3, e4, e5;
  logic signed [PW-1:0] d, n1, n2, n3;
  logic hit, last, slot_ok;
  logic [CntW-1:0] cnt_clip;

  assign {cz, cx, bz, bx, az, ax} = rd_q;
  assign e0 = DW'(bz) - DW'(cz);
  assign e1 = DW'(ax) - DW'(cx);
  assign e2 = DW'(cx) - DW'(bx);
  assign e3 = DW'(az) - DW'(cz);
  assign e4 = DW'(px_q) - DW'(cx);
  assign e5 = DW'(pz_q) - DW'(cz);

  assign d  = m_q[0] + m_q[1];
  assign n1 = m_q[2] + m_q[3];
  assign n2 = m_q[4] + m_q[5];
  assign n3 = d - n1 - n2;

  always_comb begin
    hit = 1'b0;
    if (d != '0) begin
      hit = ((n1 == '0) || (n1[PW-1] == d[PW-1])) &&
            ((n2 == '0) || (n2[PW-1] == d[PW-1])) &&
            ((n3 == '0) || (n3[PW-1] == d[PW-1]));
    end
  end

  assign cnt_clip = (int'(count_i) > MaxTriangles) ? CntW'(MaxTriangles) : CntW'(count_i);
  assign last = (idx_q + 1'b1 >= n_q);
  assign slot_ok = (int'(slot_i) < MaxTriangles);
  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;

  always_ff @(posedge clk_i) begin
    if (q_pop_o && cmd_i == CMD_WRITE && slot_ok) mem_q[AddrW'(slot_i)] <= tri_i;
    rd_q <= mem_q[idx_q[AddrW-1:0]];
    if (q_pop_o) begin
      px_q <= point_i[CoordBits-1:0];
      pz_q <= point_i[2*CoordBits-1:CoordBits];
    end
    if (state_q == S_MUL) begin
      m_q[0] <= PW'(e0 * e1);
      m_q[1] <= PW'(e2 * e3);
      m_q[2] <= PW'(e0 * e4);
      m_q[3] <= PW'(e2 * e5);
      m_q[4] <= PW'(-e3 * e4);
      m_q[5] <= PW'(e1 * e5);
    end
  end

  // Each slot passes through the read, multiply and test states.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (q_pop_o && cmd_i == CMD_QUERY) state_d = (cnt_clip == '0) ? S_OUT : S_READ;
      S_READ: state_d = S_MUL;
      S_MUL:  state_d = S_TEST;
      S_TEST: if (hit || last) state_d = S_OUT; else state_d = S_READ;
      S_OUT:  if (!out_valid_q) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // The scan keeps its own hit registers so that a held result stays intact
  // while the next item is already being taken in.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q <= '0;
      n_q <= '0;
      hit_q <= 1'b0;
      hit_idx_q <= '0;
      found_q <= 1'b0;
      res_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (q_pop_o) begin
        idx_q <= '0;
        n_q <= cnt_clip;
        hit_q <= 1'b0;
        hit_idx_q <= '0;
      end
      if (state_q == S_TEST) begin
        if (hit) begin
          hit_q <= 1'b1;
          hit_idx_q <= IndexWidth'(idx_q);
        end else if (!last) begin
          idx_q <= idx_q + 1'b1;
        end
      end
      if (state_q == S_OUT && !out_valid_q) begin
        out_valid_q <= 1'b1;
        found_q <= hit_q;
        res_q <= hit_idx_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o = found_q;
  assign index_o = res_q;

endmodule

// ===== src/triangle_point_locator.sv =====
// Top level of the triangle point locator.
// Depends on tpl_pkg, tpl_front and tpl_back.
//
// Write items store a triangle as the scan engine takes them from the queue; a query scans
// slots 0 to min(triangle_count, MAX_TRIANGLES)-1 with one shared tester that takes each
// slot through memory read, multiply and sign test, stops at the first hit, and yields one
// result through an output register. A held result stalls the next query at its last step.
// A two-entry queue lets new items transfer in while a scan runs. The table has no reset;
// only written slots may be scanned.
module triangle_point_locator import tpl_pkg::*; #(
  parameter int MAX_TRIANGLES = 64,
  parameter int COORD_BITS    = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CfgWidth-1:0]          cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         cmd_i,
  input  logic [IndexWidth-1:0]        slot_i,
  input  logic signed [COORD_BITS-1:0] a_x_i,
  input  logic signed [COORD_BITS-1:0] a_z_i,
  input  logic signed [COORD_BITS-1:0] b_x_i,
  input  logic signed [COORD_BITS-1:0] b_z_i,
  input  logic signed [COORD_BITS-1:0] c_x_i,
  input  logic signed [COORD_BITS-1:0] c_z_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_z_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         found_o,
  output logic [IndexWidth-1:0]        triangle_index_o
);

  localparam int IW = 1 + IndexWidth + 8 * COORD_BITS;

  logic [CfgWidth-1:0] count_q;
  logic [IW-1:0] item, qitem;
  logic q_valid, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= '0;
    else if (cfg_we_i) count_q <= cfg_wdata_i;
  end

  assign item = {cmd_i, slot_i, point_z_i, point_x_i, c_z_i, c_x_i, b_z_i, b_x_i,
                 a_z_i, a_x_i};

  tpl_front #(.ItemWidth(IW), .Depth(2)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i(item),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_item_o(qitem)
  );

  tpl_back #(.MaxTriangles(MAX_TRIANGLES), .CoordBits(COORD_BITS)) u_back (
    .clk_i, .rst_ni, .count_i(count_q),
    .q_valid_i(q_valid), .q_pop_o(q_pop),
    .cmd_i(qitem[IW-1]),
    .slot_i(qitem[IW-2 -: IndexWidth]),
    .tri_i(qitem[6*COORD_BITS-1:0]),
    .point_i(qitem[8*COORD_BITS-1:6*COORD_BITS]),
    .out_valid_o, .out_stall_i, .found_o, .index_o(triangle_index_o)
  );

  a_nf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> triangle_index_o == '0) else $error("index not zero");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(out_valid_o && out_stall_i) |-> out_valid_o && $stable(triangle_index_o))
    else $error("result dropped");
  a_hit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> {1'b0, triangle_index_o} < count_q)
    else $error("hit beyond count");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for triangle_point_locator: writes triangles, runs point
// queries and checks each found flag and slot index against an exact predictor.
// Depends on tpl_pkg and the triangle_point_locator RTL.
`timescale 1ns / 1ps

module tb_top;
  import tpl_pkg::*;

  localparam int Slots = 64;
  localparam int CycleLimit = 2000000;

  typedef struct packed {
    logic              found;
    logic [IndexWidth-1:0] index;
  } hit_t;

  typedef logic signed [15:0] coord_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgWidth-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic cmd_i = CMD_WRITE;
  logic [IndexWidth-1:0] slot_i = '0;
  coord_t a_x_i = '0, a_z_i = '0, b_x_i = '0, b_z_i = '0, c_x_i = '0, c_z_i = '0;
  coord_t point_x_i = '0, point_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic found_o;
  logic [IndexWidth-1:0] triangle_index_o;

  triangle_point_locator u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .cmd_i, .slot_i, .a_x_i, .a_z_i, .b_x_i, .b_z_i, .c_x_i, .c_z_i,
    .point_x_i, .point_z_i, .out_valid_o, .out_stall_i, .found_o, .triangle_index_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the triangle table and the count register.
  coord_t tri_shadow [Slots][6];
  bit written [Slots];
  int unsigned scan_count = 0;
  hit_t expected_hits[$];
  int errors = 0;
  int cycles = 0;
  int hold_off = 0;
  bit stall_random = 1'b1;

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic bit covers(input int s, input longint px, input longint pz);
    longint ax, az, bx, bz, cx, cz, d, n1, n2, n3;
    ax = tri_shadow[s][0]; az = tri_shadow[s][1];
    bx = tri_shadow[s][2]; bz = tri_shadow[s][3];
    cx = tri_shadow[s][4]; cz = tri_shadow[s][5];
    d  = (bz - cz) * (ax - cx) + (cx - bx) * (az - cz);
    n1 = (bz - cz) * (px - cx) + (cx - bx) * (pz - cz);
    n2 = (cz - az) * (px - cx) + (ax - cx) * (pz - cz);
    n3 = d - n1 - n2;
    if (d == 0) return 1'b0;
    if (d > 0) return n1 >= 0 && n2 >= 0 && n3 >= 0;
    return n1 <= 0 && n2 <= 0 && n3 <= 0;
  endfunction

  function automatic hit_t locate(input coord_t px, input coord_t pz);
    hit_t h;
    int n;
    h = '0;
    n = scan_count < Slots ? scan_count : Slots;
    for (int i = 0; i < n; i++) begin
      if (covers(i, longint'(px), longint'(pz))) begin
        h.found = 1'b1;
        h.index = IndexWidth'(i);
        return h;
      end
    end
    return h;
  endfunction

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver stall pattern, with an optional long hold-off.
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off--;
      out_stall_i <= 1'b1;
    end else if (stall_random) begin
      out_stall_i <= ($urandom_range(99) < ((cycles / 3000) % 2 ? 0 : 35));
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    hit_t h;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_hits.size() == 0) begin
        report("result with nothing expected");
      end else begin
        h = expected_hits.pop_front();
        if (found_o !== h.found)
          report($sformatf("found %0b expected %0b", found_o, h.found));
        if (triangle_index_o !== h.index)
          report($sformatf("index %0d expected %0d", triangle_index_o, h.index));
      end
    end
  end

  int burst_left = 0;

  // Sends one item; the expectation is queued at the accepting edge. Valid drops
  // only at the end of a burst.
  task automatic send_item(input logic cmd, input logic [5:0] slot,
                           input coord_t v[6], input coord_t px, input coord_t pz);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    cmd_i <= cmd; slot_i <= slot;
    a_x_i <= v[0]; a_z_i <= v[1]; b_x_i <= v[2];
    b_z_i <= v[3]; c_x_i <= v[4]; c_z_i <= v[5];
    point_x_i <= px; point_z_i <= pz;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (cmd == CMD_QUERY) begin
      expected_hits = {expected_hits, locate(px, pz)};
    end else begin
      for (int k = 0; k < 6; k++) tri_shadow[slot][k] = v[k];
      written[slot] = 1'b1;
    end
    @(negedge clk_i);
    if (burst_left == 0) in_valid_i <= 1'b0;
  endtask

  task automatic write_tri(input int s, input coord_t v[6]);
    coord_t p;
    p = coord_t'($urandom);
    send_item(CMD_WRITE, 6'(s), v, p, ~p);
  endtask

  task automatic query(input coord_t px, input coord_t pz);
    coord_t junk[6];
    foreach (junk[k]) junk[k] = coord_t'($urandom);
    send_item(CMD_QUERY, 6'($urandom), junk, px, pz);
  endtask

  task automatic drain();
    if (burst_left != 0) begin
      burst_left = 0;
      in_valid_i <= 1'b0;
    end
    while (expected_hits.size() != 0) @(negedge clk_i);
    repeat (3 * Slots + 10) @(negedge clk_i);
  endtask

  task automatic set_count(input int n);
    drain();
    cfg_wdata_i <= CfgWidth'(n);
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    scan_count = n;
  endtask

  function automatic coord_t rnd_coord(input bit narrow);
    if (narrow) return coord_t'($signed($urandom_range(400)) - 200);
    return coord_t'($urandom);
  endfunction

  // A query point biased to land near or inside a stored triangle.
  task automatic query_near();
    int s;
    longint px, pz;
    int w0, w1;
    s = $urandom_range(Slots - 1);
    if (!written[s] || $urandom_range(9) == 0) begin
      query(rnd_coord($urandom_range(1) != 0), rnd_coord($urandom_range(1) != 0));
      return;
    end
    w0 = $urandom_range(4);
    w1 = $urandom_range(4 - w0);
    px = (w0 * tri_shadow[s][0] + w1 * tri_shadow[s][2] + (4 - w0 - w1) * tri_shadow[s][4]) / 4;
    pz = (w0 * tri_shadow[s][1] + w1 * tri_shadow[s][3] + (4 - w0 - w1) * tri_shadow[s][5]) / 4;
    query(coord_t'(px + $signed($urandom_range(2)) - 1),
          coord_t'(pz + $signed($urandom_range(2)) - 1));
  endtask

  task automatic test_fill_table();
    coord_t v[6];
    for (int s = 0; s < Slots; s++) begin
      foreach (v[k]) v[k] = rnd_coord((s % 2) != 0);
      write_tri(s, v);
    end
  endtask

  task automatic test_directed();
    coord_t v[6];
    set_count(0);
    query(16'sd0, 16'sd0);
    set_count(3);
    v = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff};
    write_tri(0, v);
    v = '{16'sd0, 16'sd0, 16'sd16, 16'sd16, 16'sd32, 16'sd32};  // degenerate: collinear
    write_tri(1, v);
    v = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000};
    write_tri(2, v);
    query(16'sh8000, 16'sh8000);          // vertex
    query(16'sd0, 16'sh8000);             // edge
    query(16'sh7fff, 16'sh7fff);
    query(16'sh7fff, 16'sh8000);
    query(16'sd16, 16'sd16);
    query(-16'sd1, -16'sd1);
    query(16'sd0, 16'sd0);
    set_count(1);
    query(16'sh7fff, 16'sh7fff);
    set_count(2);
    query(16'sd16, 16'sd16);
  endtask

  task automatic test_random(input int n_items);
    coord_t v[6];
    int s;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(9) < 2) begin
        s = $urandom_range(Slots - 1);
        foreach (v[k]) v[k] = rnd_coord($urandom_range(2) != 0);
        write_tri(s, v);
      end else begin
        query_near();
      end
    end
  endtask

  task automatic test_backpressure();
    hold_off = 400;
    test_random(30);
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_fill_table();
    set_count(Slots);
    test_random(300);
    set_count(1);
    test_random(150);
    set_count(17);
    test_random(200);
    set_count(127);                       // beyond table: scans every slot
    test_backpressure();
    test_random(300);
    set_count(Slots);
    stall_random = 1'b0;
    test_random(50);
    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
